@@ hdl/ipv4dq_pkg.sv @@
// shared types and constants for the dotted-quad address parser
// no dependencies; compiled first
`timescale 1ns / 1ps

package ipv4dq_pkg;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [11:0] OCTET_MAX = 12'd255;
  localparam logic [1:0] LAST_DOTS = 2'd3;

  // running parse state of one string
  typedef struct packed {
    logic [7:0]  octet_value;
    logic        octet_has_digit;
    logic [1:0]  octets_done;
    logic [23:0] finished_octets;
    logic        error_seen;
  } parse_state_t;

  // result produced when a string ends
  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic        error;
  } parse_result_t;

endpackage

@@ hdl/ipv4dq_if.sv @@
// valid/ready channel interfaces for characters in and addresses out
// no dependencies
`timescale 1ns / 1ps

interface ipv4dq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source (output valid, output character, output end_of_string, input ready);
  modport sink (input valid, input character, input end_of_string, output ready);
endinterface

interface ipv4dq_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        error;

  modport source (output valid, output address, output error, input ready);
  modport sink (input valid, input address, input error, output ready);
endinterface

@@ hdl/ipv4dq_step.sv @@
// next-state and result logic for one character of the address text
// depends on ipv4dq_pkg
`timescale 1ns / 1ps

module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t  cur,
  input  logic [7:0]                character,
  input  logic                      end_of_string,
  output ipv4dq_pkg::parse_state_t  nxt,
  output ipv4dq_pkg::parse_result_t res
);

  logic        is_end;
  logic        is_digit;
  logic        is_dot;
  logic [11:0] accum;
  logic        bad;

  assign is_end   = end_of_string || (character == ipv4dq_pkg::CHAR_NUL);
  assign is_digit = (character >= ipv4dq_pkg::CHAR_ZERO) &&
                    (character <= ipv4dq_pkg::CHAR_NINE);
  assign is_dot   = (character == ipv4dq_pkg::CHAR_DOT);

  // value * 10 + digit as (v << 3) + (v << 1) + digit
  assign accum = {1'b0, cur.octet_value, 3'b000} + {3'b000, cur.octet_value, 1'b0} +
                 {8'h00, character[3:0]};

  assign bad = cur.error_seen || !cur.octet_has_digit ||
               (cur.octets_done != ipv4dq_pkg::LAST_DOTS);

  always_comb begin
    nxt           = cur;
    res.valid     = 1'b0;
    res.address   = {cur.octet_value, cur.finished_octets};
    res.error     = 1'b0;
    if (is_end) begin
      res.valid = 1'b1;
      res.error = bad;
      if (bad) begin
        res.address = '0;
      end
      nxt = '0;
    end else if (!cur.error_seen) begin
      if (is_digit) begin
        if (accum > ipv4dq_pkg::OCTET_MAX) begin
          nxt.error_seen = 1'b1;
        end else begin
          nxt.octet_value     = accum[7:0];
          nxt.octet_has_digit = 1'b1;
        end
      end else if (is_dot) begin
        if (!cur.octet_has_digit || (cur.octets_done == ipv4dq_pkg::LAST_DOTS)) begin
          nxt.error_seen = 1'b1;
        end else begin
          case (cur.octets_done)
            2'd0:    nxt.finished_octets[7:0]   = cur.octet_value;
            2'd1:    nxt.finished_octets[15:8]  = cur.octet_value;
            default: nxt.finished_octets[23:16] = cur.octet_value;
          endcase
          nxt.octets_done     = cur.octets_done + 2'd1;
          nxt.octet_value     = '0;
          nxt.octet_has_digit = 1'b0;
        end
      end else begin
        // anything that is not a digit, a dot or a terminator
        nxt.error_seen = 1'b1;
      end
    end
  end

endmodule

@@ hdl/ipv4_dotted_quad_parser_core.sv @@
// top level of the dotted-quad address parser
// depends on ipv4dq_pkg, ipv4dq_if and ipv4dq_step
//
//   channel  dir  payload                          role
//   chars    in   character[7:0], end_of_string    one byte of address text
//   result   out  address[31:0], error             one per terminated string
//
// each request is taken into an input register, parsed from that register
// and, when it ends a string, written to the output register; one request per
// cycle is sustained while the output register does not stall
// the output register is the only place that can stall; a terminator waits in
// the input register while an earlier result is held, characters that give no
// result pass through regardless
// rst is synchronous and clears both valid flags and the parse state
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_core (
  input logic          clk,
  input logic          rst,
  ipv4dq_char_if.sink  chars,
  ipv4dq_addr_if.source result
);

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eos;

  // parse state across characters of one string
  ipv4dq_pkg::parse_state_t  state;
  ipv4dq_pkg::parse_state_t  state_next;
  ipv4dq_pkg::parse_result_t step_res;

  // output register
  logic        out_valid;
  logic [31:0] out_address;
  logic        out_error;

  logic in_fire;

  ipv4dq_step u_step (
    .cur           (state),
    .character     (in_char),
    .end_of_string (in_eos),
    .nxt           (state_next),
    .res           (step_res)
  );

  // the held character advances unless it needs the output register and that
  // register is full with no taker this cycle
  assign in_fire     = in_valid && (!step_res.valid || !out_valid || result.ready);
  assign chars.ready = !in_valid || in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      in_char <= chars.character;
      in_eos  <= chars.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (in_fire && step_res.valid) begin
      out_address <= step_res.address;
      out_error   <= step_res.error;
    end
  end

  assign result.valid   = out_valid;
  assign result.address = out_address;
  assign result.error   = out_error;

endmodule

@@ hdl/ipv4dq_checker.sv @@
// port-level checks for the dotted-quad address parser, bound to the top level
// depends on ipv4_dotted_quad_parser_core
`timescale 1ns / 1ps

module ipv4dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        chars_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_address,
  input logic        result_error
);

  // a failed parse never leaks a partial address
  a_error_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_error |-> result_address == 32'h0)
    else $error("error result with nonzero address");

  // nothing comes out in the cycle after reset
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // a held result stays put until taken
  a_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_address) &&
    $stable(result_error))
    else $error("stalled result changed");

  // with the output drained the block never refuses a request
  a_ready_free : assert property (@(posedge clk) disable iff (rst)
    !result_valid && $past(!result_valid) && !$past(rst) |-> chars_ready)
    else $error("input stalled with empty output");

endmodule

bind ipv4_dotted_quad_parser_core ipv4dq_checker u_ipv4dq_checker (
  .clk            (clk),
  .rst            (rst),
  .chars_ready    (chars.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_address (result.address),
  .result_error   (result.error)
);
